// ----- sv/owtm_pkg.sv -----
// Package for the one-wire temperature sensor master: codes, types and helpers.
package owtm_pkg;

   // Sizing of the bus and of the scratchpad read
   localparam int SENSOR_LINES     = 4;
   localparam int SCRATCHPAD_BYTES = 9;

   // Request operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] REG_RESET_LOW     = 3'd0;
   localparam logic [2:0] REG_RESET_RELEASE = 3'd1;
   localparam logic [2:0] REG_SLOT          = 3'd2;
   localparam logic [2:0] REG_SHORT_PULSE   = 3'd3;
   localparam logic [2:0] REG_SAMPLE        = 3'd4;

   // Register reset values
   localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
   localparam logic [9:0] RESET_RELEASE_DEFAULT = 10'd70;
   localparam logic [7:0] SLOT_DEFAULT          = 8'd60;
   localparam logic [3:0] SHORT_PULSE_DEFAULT   = 4'd1;
   localparam logic [5:0] SAMPLE_DEFAULT        = 6'd14;

   // ROM and function command bytes
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   // Bus sequencer phases
   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_RST_LOW = 8'b0000_0010,
      PH_RST_REL = 8'b0000_0100,
      PH_WR_LOW  = 8'b0000_1000,
      PH_WR_HIGH = 8'b0001_0000,
      PH_RD_LOW  = 8'b0010_0000,
      PH_RD_WAIT = 8'b0100_0000,
      PH_RD_REST = 8'b1000_0000
   } phase_type;

   // Timing registers as seen by the sequencer
   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [9:0] reset_release_time;
      logic [7:0] slot_time;
      logic [3:0] short_pulse_time;
      logic [5:0] sample_time;
   } cfg_type;

   // Sequencer state
   typedef struct packed {
      phase_type    phase;
      logic [9:0]   slot_timer;
      logic [2:0]   bit_count;
      logic [3:0]   byte_count;
      logic [7:0]   shift_byte;
      logic         command_kind;
      logic [1:0]   active_sensor;
      logic [7:0]   low_byte;
      logic [15:0]  reading;
   } state_type;

   // A zero duration counts as one microsecond
   function automatic logic [9:0] at_least_one(input logic [9:0] v);
      return (v == 10'd0) ? 10'd1 : v;
   endfunction

endpackage

// ----- sv/owtm_if.sv -----
// Handshake channel interfaces: request, result and register write.
interface owtm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [1:0] sensor;
   logic [3:0] line_levels;

   modport source (output valid, output operation, output sensor, output line_levels,
                   input ready);
   modport sink   (input valid, input operation, input sensor, input line_levels,
                   output ready);
endinterface

interface owtm_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         drive_low;
   logic               busy_res;
   logic               reading_valid;
   logic [1:0]         reading_sensor;
   logic signed [15:0] temperature;

   modport source (output valid, output drive_low, output busy_res, output reading_valid,
                   output reading_sensor, output temperature, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input reading_valid,
                   input reading_sensor, input temperature, output ready);
endinterface

interface owtm_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [9:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/owtm_csr.sv -----
// Timing register bank written through the register channel.
module owtm_csr (
   input  logic             clock,
   input  logic             reset,
   owtm_csr_if.sink         csr,
   output owtm_pkg::cfg_type cfg
);
   import owtm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; unknown indexes are dropped
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_RESET_LOW:     cfg_in.reset_low_time     = csr.data;
            REG_RESET_RELEASE: cfg_in.reset_release_time = csr.data;
            REG_SLOT:          cfg_in.slot_time          = csr.data[7:0];
            REG_SHORT_PULSE:   cfg_in.short_pulse_time   = csr.data[3:0];
            REG_SAMPLE:        cfg_in.sample_time        = csr.data[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time     <= RESET_LOW_DEFAULT;
         cfg_ff.reset_release_time <= RESET_RELEASE_DEFAULT;
         cfg_ff.slot_time          <= SLOT_DEFAULT;
         cfg_ff.short_pulse_time   <= SHORT_PULSE_DEFAULT;
         cfg_ff.sample_time        <= SAMPLE_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/owtm_core.sv -----
// Bus sequencer: request register, one-step state update and result register.
module owtm_core (
   input  logic             clock,
   input  logic             reset,
   input  owtm_pkg::cfg_type cfg,
   owtm_req_if.sink         req,
   owtm_rsp_if.source       rsp
);
   import owtm_pkg::*;

   // Request stage
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_op_ff;
   logic [1:0] in_sensor_ff;
   logic [3:0] in_levels_ff;

   // State and result stage
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         drive_low_ff;
   logic               busy_ff;
   logic               rd_valid_ff;
   logic [1:0]         rd_sensor_ff;
   logic signed [15:0] temp_ff;

   logic advance, process, req_accept;
   logic done_valid;
   logic sensor_ok;
   logic line_low;

   // Durations with zero read as one
   logic [9:0] reset_low1, reset_rel1, slot1, short1, sample1;
   logic [6:0] used_len;
   logic [7:0] read_rest;
   logic [9:0] timer_dec;
   logic [7:0] shr_byte, next_cmd;
   logic [2:0] bit_inc;
   logic [3:0] byte_inc;

   assign advance    = !rsp_valid_ff || rsp.ready;
   assign process    = in_valid_ff && advance;
   assign req.ready  = !in_valid_ff || advance;
   assign req_accept = req.valid && req.ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = process || (rsp_valid_ff && !rsp.ready);

   assign reset_low1 = at_least_one(cfg.reset_low_time);
   assign reset_rel1 = at_least_one(cfg.reset_release_time);
   assign slot1      = at_least_one({2'b00, cfg.slot_time});
   assign short1     = at_least_one({6'b00_0000, cfg.short_pulse_time});
   assign sample1    = at_least_one({4'b0000, cfg.sample_time});

   // Rest of a read slot, never below one
   assign used_len  = short1[6:0] + sample1[6:0];
   assign read_rest = (slot1[7:0] > {1'b0, used_len}) ? (slot1[7:0] - {1'b0, used_len})
                                                      : 8'd1;

   assign timer_dec = state_ff.slot_timer - 10'd1;
   assign shr_byte  = state_ff.shift_byte >> 1;
   assign bit_inc   = state_ff.bit_count + 3'd1;
   assign byte_inc  = state_ff.byte_count + 4'd1;
   assign next_cmd  = state_ff.command_kind ? CMD_READ_PAD : CMD_CONVERT;
   assign sensor_ok = ({3'b000, in_sensor_ff} < 5'(SENSOR_LINES));

   // One item's step of the sequencer
   always_comb begin
      state_in   = state_ff;
      done_valid = 1'b0;
      if (in_op_ff == OP_TICK) begin
         if (state_ff.phase != PH_IDLE) begin
            state_in.slot_timer = timer_dec;
            if (timer_dec == 10'd0) begin
               unique case (state_ff.phase)
                  PH_RST_LOW: begin
                     state_in.phase      = PH_RST_REL;
                     state_in.slot_timer = reset_rel1;
                  end
                  PH_RST_REL: begin
                     state_in.shift_byte = CMD_SKIP_ROM;
                     state_in.byte_count = 4'd0;
                     state_in.bit_count  = 3'd0;
                     state_in.phase      = PH_WR_LOW;
                     state_in.slot_timer = CMD_SKIP_ROM[0] ? short1 : slot1;
                  end
                  PH_WR_LOW: begin
                     state_in.phase      = PH_WR_HIGH;
                     state_in.slot_timer = state_ff.shift_byte[0] ? slot1 : short1;
                  end
                  PH_WR_HIGH: begin
                     state_in.shift_byte = shr_byte;
                     state_in.bit_count  = bit_inc;
                     if (bit_inc != 3'd0) begin
                        state_in.phase      = PH_WR_LOW;
                        state_in.slot_timer = shr_byte[0] ? short1 : slot1;
                     end else if (state_ff.byte_count == 4'd0) begin
                        // skip-ROM sent, now the function byte
                        state_in.byte_count = 4'd1;
                        state_in.shift_byte = next_cmd;
                        state_in.phase      = PH_WR_LOW;
                        state_in.slot_timer = next_cmd[0] ? short1 : slot1;
                     end else if (!state_ff.command_kind) begin
                        state_in.phase      = PH_IDLE;
                        state_in.slot_timer = 10'd0;
                        state_in.byte_count = 4'd0;
                     end else begin
                        state_in.byte_count = 4'd0;
                        state_in.shift_byte = 8'd0;
                        state_in.phase      = PH_RD_LOW;
                        state_in.slot_timer = short1;
                     end
                  end
                  PH_RD_LOW: begin
                     state_in.phase      = PH_RD_WAIT;
                     state_in.slot_timer = sample1;
                  end
                  PH_RD_WAIT: begin
                     state_in.shift_byte = {in_levels_ff[state_ff.active_sensor], shr_byte[6:0]};
                     state_in.phase      = PH_RD_REST;
                     state_in.slot_timer = {2'b00, read_rest};
                  end
                  PH_RD_REST: begin
                     state_in.bit_count = bit_inc;
                     if (bit_inc != 3'd0) begin
                        state_in.phase      = PH_RD_LOW;
                        state_in.slot_timer = short1;
                     end else begin
                        // byte complete: keep the two reading bytes
                        if (state_ff.byte_count == 4'd0) begin
                           state_in.low_byte = state_ff.shift_byte;
                        end else if (state_ff.byte_count == 4'd1) begin
                           state_in.reading = {state_ff.shift_byte, state_ff.low_byte};
                        end
                        if (byte_inc >= 4'(SCRATCHPAD_BYTES)) begin
                           state_in.phase      = PH_IDLE;
                           state_in.slot_timer = 10'd0;
                           state_in.byte_count = 4'd0;
                           done_valid          = 1'b1;
                        end else begin
                           state_in.byte_count = byte_inc;
                           state_in.shift_byte = 8'd0;
                           state_in.phase      = PH_RD_LOW;
                           state_in.slot_timer = short1;
                        end
                     end
                  end
                  default: begin
                     state_in.phase      = PH_IDLE;
                     state_in.slot_timer = 10'd0;
                  end
               endcase
            end
         end
      end else if ((in_op_ff == OP_START || in_op_ff == OP_READ) &&
                   state_ff.phase == PH_IDLE && sensor_ok) begin
         // New command starts with the reset pulse
         state_in.command_kind  = (in_op_ff == OP_READ);
         state_in.active_sensor = in_sensor_ff;
         state_in.bit_count     = 3'd0;
         state_in.byte_count    = 4'd0;
         state_in.shift_byte    = 8'd0;
         state_in.phase         = PH_RST_LOW;
         state_in.slot_timer    = reset_low1;
      end
   end

   assign line_low = (state_in.phase == PH_RST_LOW) || (state_in.phase == PH_WR_LOW) ||
                     (state_in.phase == PH_RD_LOW);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         state_ff.phase       <= PH_IDLE;
         state_ff.slot_timer  <= 10'd0;
         state_ff.bit_count   <= 3'd0;
         state_ff.byte_count  <= 4'd0;
         state_ff.shift_byte  <= 8'd0;
         state_ff.command_kind  <= 1'b0;
         state_ff.active_sensor <= 2'd0;
         state_ff.low_byte    <= 8'd0;
         state_ff.reading     <= 16'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff     <= req.operation;
         in_sensor_ff <= req.sensor;
         in_levels_ff <= req.line_levels;
      end
      if (process) begin
         drive_low_ff <= line_low ? (4'b0001 << state_in.active_sensor) : 4'b0000;
         busy_ff      <= (state_in.phase != PH_IDLE);
         rd_valid_ff  <= done_valid;
         rd_sensor_ff <= state_in.active_sensor;
         temp_ff      <= state_in.reading;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.drive_low      = drive_low_ff;
   assign rsp.busy_res       = busy_ff;
   assign rsp.reading_valid  = rd_valid_ff;
   assign rsp.reading_sensor = rd_sensor_ff;
   assign rsp.temperature    = temp_ff;

   // Checks
   a_idle_timer_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_IDLE |-> state_ff.slot_timer == 10'd0)
      else $error("idle sequencer with running timer");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> $stable(state_ff))
      else $error("sequencer advanced during result stall");

   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rd_valid_ff |-> !busy_ff)
      else $error("read finished while still busy");

   a_drive_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(drive_low_ff) && (busy_ff || drive_low_ff == 4'b0000))
      else $error("bad line drive pattern");

endmodule

// ----- sv/one_wire_temp_sensor_master.sv -----
// Top level of the one-wire temperature sensor master.
//
//   Channel  Dir   Payload                                              Handshake
//   req      in    operation, sensor, line_levels                       valid/ready
//   rsp      out   drive_low, busy_res, reading_valid, reading_sensor,  valid/ready
//                  temperature
//   csr      in    index, data (timing registers)                       valid/ready
//
// One request is taken every cycle while rsp is not stalled; its result goes
// through the request register, then the result register after the state update.
// Reset is synchronous and active high: sequencer idle, reading zero, timing
// registers at their defaults.
// When rsp is stalled the result and the waiting request hold and req.ready
// drops once the request register is full.
module one_wire_temp_sensor_master (
   input logic        clock,
   input logic        reset,
   owtm_req_if.sink   req,
   owtm_rsp_if.source rsp,
   owtm_csr_if.sink   csr
);
   import owtm_pkg::*;

   cfg_type cfg;

   owtm_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   owtm_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule
